[design/bis_pkg.sv]
// Shared types and codes for the bilinear image scaler.
package bis_pkg;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   localparam logic [2:0] CSR_SRC_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_SRC_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_DEST_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_DEST_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_PIXEL_FMT   = 3'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_UNSUP   = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

   localparam logic [3:0] FMT_LUT8    = 4'd0;
   localparam logic [3:0] FMT_RGB15   = 4'd1;
   localparam logic [3:0] FMT_BGR15   = 4'd2;
   localparam logic [3:0] FMT_RGB15PC = 4'd3;
   localparam logic [3:0] FMT_BGR15PC = 4'd4;
   localparam logic [3:0] FMT_RGB16   = 4'd5;
   localparam logic [3:0] FMT_BGR16   = 4'd6;
   localparam logic [3:0] FMT_RGB16PC = 4'd7;
   localparam logic [3:0] FMT_BGR16PC = 4'd8;
   localparam logic [3:0] FMT_RGB24   = 4'd9;
   localparam logic [3:0] FMT_BGR24   = 4'd10;
   localparam logic [3:0] FMT_ARGB32  = 4'd11;
   localparam logic [3:0] FMT_BGRA32  = 4'd12;
   localparam logic [3:0] FMT_RGBA32  = 4'd13;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic        operation;
      logic [11:0] column;
      logic [11:0] row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [2:0] byte_count;
   } rsp_type;

endpackage

[design/bilinear_image_scaler_unit.sv]
// Bilinear image scaler: banked frame store, step divider and blend pipeline.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+-----------------------------------
//  request | start, busy, req_item         | taken when start && !busy
//  result  | rsp_strobe, rsp_item          | one-cycle strobe, no back pressure
//  config  | csr_valid, csr_ready,         | written when csr_valid && csr_ready
//          | csr_index, csr_data           |
//
// One item per cycle unless busy; render results pass through every pipeline stage.
// Four frame store banks (row and column parity) serve the four neighbors at once.
// After reset and after each register write the step divider runs, x then y,
// one quotient bit per cycle; busy and !csr_ready then.
// Reset is synchronous; the frame store is not cleared. Results are never stalled.
module bilinear_image_scaler_unit #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int FRAC_BITS      = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bis_pkg::req_type req_item,
   output logic             rsp_strobe,
   output bis_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [12:0]      csr_data
);

   localparam int MAXS   = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
   localparam int SRCB   = $clog2(MAXS + 1);
   localparam int DVW    = SRCB + FRAC_BITS;
   localparam int CNTW   = $clog2(DVW);
   localparam int AW     = 12 + DVW;
   localparam int IW     = AW - FRAC_BITS;
   localparam int XW     = $clog2(MAX_SRC_WIDTH);
   localparam int YW     = $clog2(MAX_SRC_HEIGHT);
   localparam int XAW    = (XW > 1) ? XW - 1 : 1;
   localparam int YAW    = (YW > 1) ? YW - 1 : 1;
   localparam int BAW    = XAW + YAW;
   localparam int BDEPTH = 1 << BAW;
   localparam int HW     = 8 + FRAC_BITS + 1;
   localparam int VW     = HW + FRAC_BITS + 2;

   // configuration
   logic [8:0]  src_width_ff, src_height_ff;
   logic [12:0] dest_width_ff, dest_height_ff;
   logic [3:0]  pixel_format_ff;
   logic        csr_we;

   assign csr_we = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff    <= 9'd256;
         src_height_ff   <= 9'd256;
         dest_width_ff   <= 13'd256;
         dest_height_ff  <= 13'd256;
         pixel_format_ff <= bis_pkg::FMT_RGB24;
      end else if (csr_we) begin
         unique case (csr_index)
            bis_pkg::CSR_SRC_WIDTH:   src_width_ff    <= csr_data[8:0];
            bis_pkg::CSR_SRC_HEIGHT:  src_height_ff   <= csr_data[8:0];
            bis_pkg::CSR_DEST_WIDTH:  dest_width_ff   <= csr_data;
            bis_pkg::CSR_DEST_HEIGHT: dest_height_ff  <= csr_data;
            bis_pkg::CSR_PIXEL_FMT:   pixel_format_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   logic [SRCB-1:0] eff_w, eff_h;

   always_comb begin
      if (src_width_ff == '0) eff_w = SRCB'(1);
      else if (32'(src_width_ff) > MAX_SRC_WIDTH) eff_w = SRCB'(MAX_SRC_WIDTH);
      else eff_w = SRCB'(src_width_ff);
      if (src_height_ff == '0) eff_h = SRCB'(1);
      else if (32'(src_height_ff) > MAX_SRC_HEIGHT) eff_h = SRCB'(MAX_SRC_HEIGHT);
      else eff_h = SRCB'(src_height_ff);
   end

   // step divider, x then y
   logic            div_run_ff, div_axis_ff, div_load_ff;
   logic [CNTW-1:0] div_cnt_ff;
   logic [12:0]     div_rem_ff, div_rem_in;
   logic [DVW-1:0]  div_quo_ff, div_quo_in;
   logic [DVW-1:0]  x_step_ff, y_step_ff;
   logic [13:0]     div_shift;
   logic [12:0]     div_den;
   logic            div_ge;

   assign div_den   = div_axis_ff ? dest_height_ff : dest_width_ff;
   assign div_shift = {div_rem_ff, div_quo_ff[DVW-1]};
   assign div_ge    = div_shift >= {1'b0, div_den};

   always_comb begin
      div_rem_in = div_ge ? 13'(div_shift - {1'b0, div_den}) : div_shift[12:0];
      div_quo_in = {div_quo_ff[DVW-2:0], div_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff  <= 1'b1;
         div_load_ff <= 1'b1;
         div_axis_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (csr_we) begin
         div_run_ff  <= 1'b1;
         div_load_ff <= 1'b1;
         div_axis_ff <= 1'b0;
      end else if (div_run_ff) begin
         if (div_load_ff) begin
            div_load_ff <= 1'b0;
            div_cnt_ff  <= CNTW'(DVW - 1);
            div_rem_ff  <= '0;
            div_quo_ff  <= div_axis_ff ? (DVW'(eff_h) << FRAC_BITS)
                                       : (DVW'(eff_w) << FRAC_BITS);
         end else begin
            div_rem_ff <= div_rem_in;
            div_quo_ff <= div_quo_in;
            div_cnt_ff <= div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               if (div_axis_ff) begin
                  y_step_ff  <= (div_den == '0) ? '0 : div_quo_in;
                  div_run_ff <= 1'b0;
               end else begin
                  x_step_ff   <= (div_den == '0) ? '0 : div_quo_in;
                  div_axis_ff <= 1'b1;
                  div_load_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign busy      = div_run_ff;
   assign csr_ready = !div_run_ff;

   // stage 1: coordinate products
   logic            accept;
   logic            v1_ff, op1_ff;
   logic [11:0]     col1_ff, row1_ff;
   logic [23:0]     rgb1_ff;
   logic [1:0]      stat1_ff, stat1_in;
   logic [AW-1:0]   ax1_ff, ay1_ff;

   assign accept = start && !busy;

   always_comb begin
      if (pixel_format_ff == bis_pkg::FMT_LUT8 || pixel_format_ff > bis_pkg::FMT_RGBA32)
         stat1_in = bis_pkg::STATUS_UNSUP;
      else if ({1'b0, req_item.column} >= dest_width_ff ||
               {1'b0, req_item.row} >= dest_height_ff)
         stat1_in = bis_pkg::STATUS_OUTSIDE;
      else
         stat1_in = bis_pkg::STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= accept;
      op1_ff   <= req_item.operation;
      col1_ff  <= req_item.column;
      row1_ff  <= req_item.row;
      rgb1_ff  <= {req_item.red, req_item.green, req_item.blue};
      stat1_ff <= stat1_in;
      ax1_ff   <= AW'(req_item.column) * AW'(x_step_ff);
      ay1_ff   <= AW'(req_item.row) * AW'(y_step_ff);
   end

   // stage 2: map to source, access frame store banks
   logic [IW-1:0]        idx_x, idx_y;
   logic [SRCB-1:0]      wm1, hm1;
   logic [XW-1:0]        x0, x1;
   logic [YW-1:0]        y0, y1;
   logic [FRAC_BITS-1:0] fx, fy;
   logic                 load_ok;
   logic [3:0]           bank_we, bank_re;
   logic [3:0][BAW-1:0]  bank_addr;
   wire  [3:0][23:0]     bank_rd;
   logic [11:0]          col_half, row_half, xc_half, yc_half;
   logic [XW-1:0]        xc;
   logic [YW-1:0]        yc;

   assign wm1 = eff_w - 1'b1;
   assign hm1 = eff_h - 1'b1;
   assign idx_x = ax1_ff[AW-1:FRAC_BITS];
   assign idx_y = ay1_ff[AW-1:FRAC_BITS];

   always_comb begin
      if (idx_x >= IW'(wm1)) begin
         x0 = XW'(wm1);
         x1 = XW'(wm1);
         fx = '0;
      end else begin
         x0 = XW'(idx_x);
         x1 = XW'(idx_x) + 1'b1;
         fx = ax1_ff[FRAC_BITS-1:0];
      end
      if (idx_y >= IW'(hm1)) begin
         y0 = YW'(hm1);
         y1 = YW'(hm1);
         fy = '0;
      end else begin
         y0 = YW'(idx_y);
         y1 = YW'(idx_y) + 1'b1;
         fy = ay1_ff[FRAC_BITS-1:0];
      end
   end

   assign load_ok  = v1_ff && op1_ff == bis_pkg::OP_LOAD &&
                     32'(col1_ff) < MAX_SRC_WIDTH && 32'(row1_ff) < MAX_SRC_HEIGHT;
   assign col_half = col1_ff >> 1;
   assign row_half = row1_ff >> 1;

   always_comb begin
      for (int bk = 0; bk < 4; bk++) begin
         xc      = (x0[0] == bk[0]) ? x0 : x1;
         yc      = (y0[0] == bk[1]) ? y0 : y1;
         xc_half = 12'(xc) >> 1;
         yc_half = 12'(yc) >> 1;
         bank_we[bk] = load_ok && col1_ff[0] == bk[0] && row1_ff[0] == bk[1];
         bank_re[bk] = v1_ff && op1_ff == bis_pkg::OP_RENDER;
         if (op1_ff == bis_pkg::OP_LOAD)
            bank_addr[bk] = {row_half[YAW-1:0], col_half[XAW-1:0]};
         else
            bank_addr[bk] = {yc_half[YAW-1:0], xc_half[XAW-1:0]};
      end
   end

   for (genvar bk = 0; bk < 4; bk++) begin : g_bank
      logic [23:0] mem [BDEPTH];
      logic [23:0] rd_ff;
      always_ff @(posedge clock) begin
         if (bank_we[bk]) mem[bank_addr[bk]] <= rgb1_ff;
         if (bank_re[bk]) rd_ff <= mem[bank_addr[bk]];
      end
      assign bank_rd[bk] = rd_ff;
   end

   logic                 v2_ff;
   logic [1:0]           stat2_ff;
   logic [FRAC_BITS-1:0] fx2_ff, fy2_ff;
   logic [3:0]           par2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff && op1_ff == bis_pkg::OP_RENDER;
      stat2_ff <= stat1_ff;
      fx2_ff   <= fx;
      fy2_ff   <= fy;
      par2_ff  <= {y1[0], y0[0], x1[0], x0[0]};
   end

   // stage 3: horizontal blend
   logic [23:0]          q00, q10, q01, q11;
   logic [FRAC_BITS:0]   wx0, wx1;
   logic                 v3_ff;
   logic [1:0]           stat3_ff;
   logic [FRAC_BITS-1:0] fy3_ff;
   logic [2:0][HW-1:0]   top3_ff, bot3_ff;

   assign q00 = bank_rd[{par2_ff[2], par2_ff[0]}];
   assign q10 = bank_rd[{par2_ff[2], par2_ff[1]}];
   assign q01 = bank_rd[{par2_ff[3], par2_ff[0]}];
   assign q11 = bank_rd[{par2_ff[3], par2_ff[1]}];
   assign wx1 = {1'b0, fx2_ff};
   assign wx0 = (FRAC_BITS + 1)'(1 << FRAC_BITS) - wx1;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      stat3_ff <= stat2_ff;
      fy3_ff   <= fy2_ff;
      for (int c = 0; c < 3; c++) begin
         top3_ff[c] <= HW'(q00[c*8 +: 8]) * HW'(wx0) + HW'(q10[c*8 +: 8]) * HW'(wx1);
         bot3_ff[c] <= HW'(q01[c*8 +: 8]) * HW'(wx0) + HW'(q11[c*8 +: 8]) * HW'(wx1);
      end
   end

   // stage 4: vertical blend
   logic [FRAC_BITS:0] wy0, wy1;
   logic [2:0][VW-1:0] vsum;
   logic               v4_ff;
   logic [1:0]         stat4_ff;
   logic [2:0][7:0]    ch4_ff;

   assign wy1 = {1'b0, fy3_ff};
   assign wy0 = (FRAC_BITS + 1)'(1 << FRAC_BITS) - wy1;

   always_comb begin
      for (int c = 0; c < 3; c++)
         vsum[c] = VW'(top3_ff[c]) * VW'(wy0) + VW'(bot3_ff[c]) * VW'(wy1);
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      stat4_ff <= stat3_ff;
      for (int c = 0; c < 3; c++) ch4_ff[c] <= vsum[c][2*FRAC_BITS +: 8];
   end

   // stage 5: pack
   logic [7:0]       r, g, b, hi, lo;
   logic [15:0]      px15, px16;
   bis_pkg::rsp_type rsp_in, rsp_ff;
   logic             strobe_ff;

   assign r    = ch4_ff[2];
   assign g    = ch4_ff[1];
   assign b    = ch4_ff[0];
   assign hi   = pixel_format_ff[0] ? r : b;
   assign lo   = pixel_format_ff[0] ? b : r;
   assign px15 = {1'b0, hi[7:3], g[7:3], lo[7:3]};
   assign px16 = {hi[7:3], g[7:2], lo[7:3]};

   always_comb begin
      rsp_in = '0;
      rsp_in.status = stat4_ff;
      if (stat4_ff == bis_pkg::STATUS_OK) begin
         unique case (pixel_format_ff)
            bis_pkg::FMT_RGB15, bis_pkg::FMT_BGR15: begin
               {rsp_in.byte0, rsp_in.byte1} = px15;
               rsp_in.byte_count = 3'd2;
            end
            bis_pkg::FMT_RGB15PC, bis_pkg::FMT_BGR15PC: begin
               {rsp_in.byte1, rsp_in.byte0} = px15;
               rsp_in.byte_count = 3'd2;
            end
            bis_pkg::FMT_RGB16, bis_pkg::FMT_BGR16: begin
               {rsp_in.byte0, rsp_in.byte1} = px16;
               rsp_in.byte_count = 3'd2;
            end
            bis_pkg::FMT_RGB16PC, bis_pkg::FMT_BGR16PC: begin
               {rsp_in.byte1, rsp_in.byte0} = px16;
               rsp_in.byte_count = 3'd2;
            end
            bis_pkg::FMT_RGB24: begin
               {rsp_in.byte0, rsp_in.byte1, rsp_in.byte2} = {r, g, b};
               rsp_in.byte_count = 3'd3;
            end
            bis_pkg::FMT_BGR24: begin
               {rsp_in.byte0, rsp_in.byte1, rsp_in.byte2} = {b, g, r};
               rsp_in.byte_count = 3'd3;
            end
            bis_pkg::FMT_ARGB32: begin
               {rsp_in.byte0, rsp_in.byte1, rsp_in.byte2, rsp_in.byte3} =
                  {bis_pkg::ALPHA_OPAQUE, r, g, b};
               rsp_in.byte_count = 3'd4;
            end
            bis_pkg::FMT_BGRA32: begin
               {rsp_in.byte0, rsp_in.byte1, rsp_in.byte2, rsp_in.byte3} =
                  {b, g, r, bis_pkg::ALPHA_OPAQUE};
               rsp_in.byte_count = 3'd4;
            end
            bis_pkg::FMT_RGBA32: begin
               {rsp_in.byte0, rsp_in.byte1, rsp_in.byte2, rsp_in.byte3} =
                  {r, g, b, bis_pkg::ALPHA_OPAQUE};
               rsp_in.byte_count = 3'd4;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= v4_ff;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
